>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the radix text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define SIRT_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define SIRT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sirt_pkg.sv
// Shared constants, types and helper functions of the radix text converter.
package sirt_pkg;

	localparam int WORD_BITS = 32;
	localparam int DIGIT_W   = 6;
	localparam int RADIX_W   = 6;
	localparam int CHAR_W    = 7;
	localparam int IDX_W     = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int PREFIX_LVLS = $clog2(WORD_BITS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(8'h61);
	localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2D);
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture a new number, clear the digit row
		logic step;        // shift one magnitude bit into the digit row
		logic next_digit;  // move the read pointer one digit down
		logic sign_out;    // present '-' instead of a digit
	} sirt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic negative;     // the captured number is below zero
		logic final_digit;  // the read pointer is on the least significant digit
	} sirt_status_t;

	// Out-of-range bases are clamped into two to thirty-six.
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DEC_DIGITS) begin
			res = CH_ZERO + CHAR_W'(d);
		end else begin
			res = CH_A + CHAR_W'(d - DEC_DIGITS);
		end
		return res;
	endfunction

endpackage

>>> hdl/sirt_if.sv
// Valid/ready channel interfaces for numbers in and characters out.
interface sirt_in_if;
	import sirt_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sirt_out_if;
	import sirt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink   (input valid, input character, input last_char, output ready);
endinterface

>>> hdl/signed_integer_to_radix_text.sv
// Top level of the signed integer to radix text converter.
// Converts one signed 32-bit number per transfer on the number channel into its text in
// the base held by the radix register (2 to 36, 10 after reset; smaller codes act as 2,
// larger as 36), one ASCII character per transfer on the text channel, most significant
// first, with a leading '-' for negative numbers and last_char set on the final digit.
// Digits 10 and up are lowercase letters, zero gives a single '0', and the most negative
// number converts exactly. No terminator is sent. One number is handled at a time: the
// transfer in is followed by the conversion, in which a row of 32 base-r digit cells
// doubles and adds one magnitude bit per cycle, then by the characters, each sent when
// the text side is ready. The converter is ready again on the cycle after the last
// character's transfer. The user must write the radix only while the converter is idle;
// the block itself does not enforce it.
`include "assert_macros.svh"

module signed_integer_to_radix_text (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_we,
	input  logic [sirt_pkg::RADIX_W-1:0] radix_wdata,
	sirt_in_if.sink                      number,
	sirt_out_if.source                   text
);
	import sirt_pkg::*;

	sirt_cmd_t    cmd;
	sirt_status_t status;

	// The controller sequences load, conversion and the character transfers.
	sirt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the base, the magnitude and the digit row, and
	// forms the character presented on the text channel.
	sirt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.value       (number.value),
		.cmd         (cmd),
		.status      (status),
		.character   (text.character),
		.last_char   (text.last_char)
	);

	// The converter never takes a number while it still shows a character.
	`SIRT_ASSERT_NOW(a_no_overlap, number.ready, !text.valid, "input ready while output valid")
	// After a number's transfer the converter stays busy for the conversion.
	`SIRT_ASSERT_NEXT(a_busy_after_load, number.valid && number.ready, !number.ready,
		"ready again right after a number transfer")
	// The sign is never the final character.
	`SIRT_ASSERT_NOW(a_sign_not_last, text.valid && text.character == CH_MINUS, !text.last_char,
		"minus sign flagged as last character")
	// After the final character's transfer the converter is idle again.
	`SIRT_ASSERT_NEXT(a_idle_after_last, text.valid && text.ready && text.last_char, number.ready,
		"not idle after the last character")

endmodule

>>> hdl/sirt_ctrl.sv
// Controller state machine: conversion sequencing and character handshakes.
module sirt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sirt_pkg::sirt_status_t status,
	output sirt_pkg::sirt_cmd_t    cmd
);
	import sirt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SIGN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(WORD_BITS - 1);

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [IDX_W-1:0] steps_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SIGN) || (state_q == S_EMIT);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.sign_out   = (state_q == S_SIGN);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.step = 1'b1;
				if (steps_q == LAST_STEP) begin
					state_d = status.negative ? S_SIGN : S_EMIT;
				end
			end
			S_SIGN: begin
				if (out_ready) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_ready) begin
					if (status.final_digit) begin
						state_d = S_IDLE;
					end else begin
						cmd.next_digit = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				steps_q <= '0;
			end else if (cmd.step) begin
				steps_q <= steps_q + IDX_W'(1);
			end
		end
	end

endmodule

>>> hdl/sirt_dp.sv
// Datapath: radix register, magnitude shifter, row of base-r digit cells, character select.
module sirt_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        radix_we,
	input  logic [sirt_pkg::RADIX_W-1:0] radix_wdata,
	input  logic [sirt_pkg::WORD_BITS-1:0] value,
	input  sirt_pkg::sirt_cmd_t          cmd,
	output sirt_pkg::sirt_status_t       status,
	output logic [sirt_pkg::CHAR_W-1:0]  character,
	output logic                        last_char
);
	import sirt_pkg::*;

	logic [RADIX_W-1:0]   radix_q;
	logic [WORD_BITS-1:0] mag_q;
	logic [DIGIT_W-1:0]   cells_q [WORD_BITS];
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 neg_q;

	logic [RADIX_W-1:0]   r_eff;
	logic [WORD_BITS-1:0] gen;
	logic [WORD_BITS-1:0] prop;
	logic [WORD_BITS-1:0] gp;
	logic [WORD_BITS-1:0] pp;
	logic [WORD_BITS:0]   carry;
	logic [DIGIT_W-1:0]   cells_d [WORD_BITS];
	logic [CNT_W-1:0]     cnt_d;
	logic [CNT_W-1:0]     cnt_m1;
	logic [DIGIT_W-1:0]   cur_digit;

	assign r_eff = eff_radix(radix_q);

	// Doubling a digit row in base r: cell i keeps 2d + c mod r and carries
	// when 2d + c >= r. A cell generates a carry when 2d >= r and passes the
	// incoming one when 2d + 1 == r; a parallel prefix resolves the chain.
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			gen[i]  = ({1'b0, cells_q[i], 1'b0} >= {2'b00, r_eff});
			prop[i] = ({1'b0, cells_q[i], 1'b1} == {2'b00, r_eff});
		end
		gp    = gen;
		gp[0] = gen[0] | (prop[0] & mag_q[WORD_BITS-1]);
		pp    = prop;
		pp[0] = 1'b0;
		for (int l = 0; l < PREFIX_LVLS; l++) begin
			gp = gp | (pp & (gp << (1 << l)));
			pp = pp & ((pp << (1 << l)) | ~({WORD_BITS{1'b1}} << (1 << l)));
		end
		carry = {gp, mag_q[WORD_BITS-1]};
		for (int i = 0; i < WORD_BITS; i++) begin
			if (carry[i+1]) begin
				cells_d[i] = DIGIT_W'({1'b0, cells_q[i], carry[i]} - {2'b00, r_eff});
			end else begin
				cells_d[i] = {cells_q[i][DIGIT_W-2:0], carry[i]};
			end
		end
	end

	// The row only grows one digit at a time: the cell just above the top
	// occupied one becomes nonzero exactly when it receives a carry.
	assign cnt_d  = cnt_q + CNT_W'(carry[cnt_q]);
	assign cnt_m1 = cnt_d - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			mag_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < WORD_BITS; i++) begin
				cells_q[i] <= '0;
			end
		end else if (cmd.load) begin
			neg_q <= value[WORD_BITS-1];
			mag_q <= value[WORD_BITS-1] ? (~value + WORD_BITS'(1)) : value;
			cnt_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < WORD_BITS; i++) begin
				cells_q[i] <= '0;
			end
		end else if (cmd.step) begin
			mag_q   <= {mag_q[WORD_BITS-2:0], 1'b0};
			cnt_q   <= cnt_d;
			cells_q <= cells_d;
			idx_q   <= (cnt_d == '0) ? '0 : cnt_m1[IDX_W-1:0];
		end else if (cmd.next_digit) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	assign cur_digit          = cells_q[idx_q];
	assign character          = cmd.sign_out ? CH_MINUS : digit_char(cur_digit);
	assign last_char          = !cmd.sign_out && (idx_q == '0);
	assign status.negative    = neg_q;
	assign status.final_digit = (idx_q == '0);

endmodule
